@@ rtl/kbs_pkg.sv @@
`timescale 1ns / 1ps

package kbs_pkg;

  // default fraction bits of the trig values
  localparam int KBS_TRIG_FRAC_BITS = 14;

  // quarter-wave sine: angle 0..quarter turn, result in Q30
  localparam int ANGLE_W = 15;
  localparam int SIN_W = 31;
  localparam logic [ANGLE_W-1:0] QUARTER = 15'd16384;
  localparam int QSIN_LAT = 15;

  // integer bits of the steering tangent quotient
  localparam int TAN_INT_W = 14;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] speed;
    logic signed [15:0] steer_angle;
    logic signed [15:0] accel;
  } kbs_in_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic [15:0]        next_heading;
    logic signed [15:0] next_speed;
    logic               saturated;
  } kbs_out_t;

endpackage

@@ rtl/kbs_stream_if.sv @@
`timescale 1ns / 1ps

interface kbs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/kbs_delay.sv @@
`timescale 1ns / 1ps

module kbs_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < N; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[N-1];

endmodule

@@ rtl/kbs_qsin.sv @@
`timescale 1ns / 1ps

module kbs_qsin
  import kbs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [ANGLE_W-1:0] angle,
  output logic [SIN_W-1:0]   sine
);

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam int N = 6;
  localparam int HORNER_K [N] = '{156, 110, 72, 42, 20, 6};

  logic [SIN_W-1:0] r0;
  logic [SIN_W-1:0] r_p [N+1];
  logic [31:0]      x2_p [N];
  logic [30:0]      t_p [N+1];
  logic [SIN_W-1:0] r_m [N];
  logic [31:0]      x2_m [N];
  logic [31:0]      p_m [N];

  logic [46:0] ang_prod;
  logic [61:0] sq;
  logic [61:0] rt;

  assign ang_prod = 47'(angle) * 47'(PI_Q30);
  assign sq = 62'(r0) * 62'(r0);

  // radians in q30, then its square
  always_ff @(posedge clk) begin
    if (en) begin
      r0 <= ang_prod[45:15];
      r_p[0] <= r0;
      x2_p[0] <= sq[61:30];
      t_p[0] <= ONE_Q30;
    end
  end

  // horner stages: product, then exact divide by reciprocal
  for (genvar g = 0; g < N; g++) begin : g_horner
    localparam int KD = HORNER_K[g];
    localparam int SH = 32 + $clog2(KD);
    localparam logic [63:0] MUL = ((64'd1 << SH) + 64'(KD) - 64'd1) / 64'(KD);

    logic [62:0] xt;
    logic [65:0] qp;

    assign xt = 63'(x2_p[g]) * 63'(t_p[g]);
    assign qp = 66'(p_m[g]) * 66'(MUL);

    always_ff @(posedge clk) begin
      if (en) begin
        p_m[g] <= xt[61:30];
        r_m[g] <= r_p[g];
        x2_m[g] <= x2_p[g];
        t_p[g+1] <= ONE_Q30 - 31'(qp >> SH);
        r_p[g+1] <= r_m[g];
      end
    end

    if (g < N - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          x2_p[g+1] <= x2_m[g];
        end
      end
    end
  end

  assign rt = 62'(r_p[N]) * 62'(t_p[N]);

  always_ff @(posedge clk) begin
    if (en) begin
      sine <= rt[60:30];
    end
  end

endmodule

@@ rtl/kbs_div.sv @@
`timescale 1ns / 1ps

module kbs_div
  import kbs_pkg::*;
#(
  parameter int FRAC_BITS = KBS_TRIG_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [SIN_W-1:0]               num,
  input  logic [SIN_W-1:0]               den,
  output logic [FRAC_BITS+TAN_INT_W-1:0] quot
);

  localparam int QW = FRAC_BITS + TAN_INT_W;
  localparam int RW = SIN_W;

  logic [RW-1:0] rem [QW];
  logic [RW-1:0] dv [QW];
  logic [QW-1:0] lo [QW];
  logic [QW-1:0] qb [QW];

  // one quotient bit per stage, restoring
  for (genvar g = 0; g < QW; g++) begin : g_bit
    logic [RW-1:0] r_in;
    logic [RW-1:0] d_in;
    logic [QW-1:0] l_in;
    logic [QW-1:0] q_in;
    logic [RW:0]   trial;
    logic [RW:0]   diff;

    if (g == 0) begin : g_first
      assign r_in = RW'(num >> TAN_INT_W);
      assign d_in = den;
      assign l_in = {num[TAN_INT_W-1:0], {FRAC_BITS{1'b0}}};
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[g-1];
      assign d_in = dv[g-1];
      assign l_in = lo[g-1];
      assign q_in = qb[g-1];
    end

    assign trial = {r_in, l_in[QW-1]};
    assign diff = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, d_in}) begin
          rem[g] <= diff[RW-1:0];
          qb[g] <= {q_in[QW-2:0], 1'b1};
        end else begin
          rem[g] <= trial[RW-1:0];
          qb[g] <= {q_in[QW-2:0], 1'b0};
        end
        lo[g] <= {l_in[QW-2:0], 1'b0};
        dv[g] <= d_in;
      end
    end
  end

  assign quot = qb[QW-1];

endmodule

@@ rtl/kinematic_bicycle_step.sv @@
`timescale 1ns / 1ps
// throughput: one item per cycle, stalled while the output queue is full and not drained;
// the steering tangent divider (one bit per stage) sets depth
// a two-entry output queue lets the pipeline keep accepting while a result waits
// reset: synchronous, clears valid bits and the output queue and loads register defaults;
// no clearing pass, the block accepts items in the first cycle after reset

module kinematic_bicycle_step
  import kbs_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = KBS_TRIG_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  kbs_stream_if.sink             in_stream,
  kbs_stream_if.source           out_stream
);

  localparam int F = TRIG_FRAC_BITS;
  localparam int TW = F + 2;                  // signed trig width
  localparam int QW = F + TAN_INT_W;          // tangent width
  localparam int T_STAGE = QSIN_LAT + QW;     // tangent ready
  localparam int E_STAGE = T_STAGE + 4;       // last pipeline stage
  localparam int POS_STAGE = QSIN_LAT + 4;    // position done
  localparam int VW = F + 35;                 // v * trig * dt width
  localparam int QTW = F + 41;                // q * tan width

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_WHEELBASE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEER_LIMIT = 2'd2;

  localparam logic [1:0] QUAD_I = 2'd0;
  localparam logic [1:0] QUAD_II = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV = 2'd3;

  localparam logic [29:0] INV2PI_Q32 = 30'd683565276;
  localparam logic signed [VW:0] POS_HALF = (VW + 1)'(1) <<< (7 + F);
  localparam logic signed [QTW-1:0] W_HALF = QTW'(1) <<< (F - 1);

  // rounds a q30 sine to the trig fraction
  function automatic logic [F:0] to_trig(input logic [SIN_W-1:0] s);
    logic [SIN_W:0] sum;
    sum = (SIN_W + 1)'(s) + ((SIN_W + 1)'(1) << (29 - F));
    return (F + 1)'(sum >> (30 - F));
  endfunction

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [15:0] step_time;
  logic [15:0] inverse_wheelbase;
  logic [13:0] steer_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= 16'd6554;
      inverse_wheelbase <= 16'd26214;
      steer_limit <= 14'd5215;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STEP_TIME:     step_time <= cfg_data;
        REG_INV_WHEELBASE: inverse_wheelbase <= cfg_data;
        REG_STEER_LIMIT:   steer_limit <= cfg_data[13:0];
        default: ;  // index past the register list is dropped
      endcase
    end
  end

  logic signed [16:0] dt_s;
  logic signed [16:0] inv_l_s;

  assign dt_s = $signed({1'b0, step_time});
  assign inv_l_s = $signed({1'b0, inverse_wheelbase});

  // ---------------------------------------------------------------
  // flow control: whole pipeline moves on adv, output queue absorbs
  // ---------------------------------------------------------------
  logic [1:0]       q_count;
  logic             adv;
  logic [E_STAGE:0] vld;

  assign adv = (q_count != 2'd2) || out_stream.ready;
  assign in_stream.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[E_STAGE-1:0], in_stream.valid};
    end
  end

  // ---------------------------------------------------------------
  // stage 0: capture item, clamp steering
  // ---------------------------------------------------------------
  kbs_in_t            in_d;
  logic signed [16:0] st_ext;
  logic signed [16:0] lim_pos;
  logic signed [16:0] st_cl;
  logic signed [16:0] st_abs;

  assign in_d = in_stream.data;
  assign st_ext = 17'(in_d.steer_angle);
  assign lim_pos = $signed({3'b000, steer_limit});

  always_comb begin
    priority if (st_ext > lim_pos) begin
      st_cl = lim_pos;
    end else if (st_ext < -lim_pos) begin
      st_cl = -lim_pos;
    end else begin
      st_cl = st_ext;
    end
    st_abs = st_cl[16] ? -st_cl : st_cl;
  end

  logic signed [31:0] s0_px;
  logic signed [31:0] s0_py;
  logic [15:0]        s0_hd;
  logic signed [15:0] s0_v;
  logic signed [15:0] s0_ac;
  logic [13:0]        s0_mag;
  logic               s0_neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_px <= in_d.pos_x;
      s0_py <= in_d.pos_y;
      s0_hd <= in_d.heading;
      s0_v <= in_d.speed;
      s0_ac <= in_d.accel;
      s0_mag <= st_abs[13:0];
      s0_neg <= st_cl[16];
    end
  end

  // ---------------------------------------------------------------
  // four quarter-wave sine pipelines, stages 1..15
  // ---------------------------------------------------------------
  logic [ANGLE_W-1:0] ang_sin;
  logic [ANGLE_W-1:0] ang_cos;
  logic [ANGLE_W-1:0] str_sin;
  logic [ANGLE_W-1:0] str_cos;
  logic [SIN_W-1:0]   sin_a;
  logic [SIN_W-1:0]   cos_a;
  logic [SIN_W-1:0]   sin_m;
  logic [SIN_W-1:0]   cos_m;

  assign ang_sin = {1'b0, s0_hd[13:0]};
  assign ang_cos = QUARTER - ang_sin;
  assign str_sin = {1'b0, s0_mag};
  assign str_cos = QUARTER - str_sin;

  kbs_qsin u_sin_a (.clk(clk), .en(adv), .angle(ang_sin), .sine(sin_a));
  kbs_qsin u_cos_a (.clk(clk), .en(adv), .angle(ang_cos), .sine(cos_a));
  kbs_qsin u_sin_m (.clk(clk), .en(adv), .angle(str_sin), .sine(sin_m));
  kbs_qsin u_cos_m (.clk(clk), .en(adv), .angle(str_cos), .sine(cos_m));

  // steering tangent, one quotient bit per stage after the sines
  logic [QW-1:0] tan_mag;

  kbs_div #(.FRAC_BITS(F)) u_tan (
    .clk  (clk),
    .en   (adv),
    .num  (sin_m),
    .den  (cos_m),
    .quot (tan_mag)
  );

  // ---------------------------------------------------------------
  // speed and heading rate front end, stages 1..3
  // ---------------------------------------------------------------
  logic signed [32:0] s1_acdt;
  logic signed [32:0] s1_pv;
  logic signed [15:0] s1_v;
  logic               s1_neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_acdt <= 33'(s0_ac) * 33'(dt_s);
      s1_pv <= 33'(s0_v) * 33'(inv_l_s);
      s1_v <= s0_v;
      s1_neg <= s0_neg;
    end
  end

  logic signed [33:0] acs;
  logic signed [17:0] acr;
  logic signed [17:0] nvf;
  logic signed [33:0] pvs;
  logic signed [24:0] p_rnd;
  logic signed [15:0] nv_sat;
  logic               nv_flag;

  always_comb begin
    acs = 34'(s1_acdt) + 34'sd32768;
    acr = 18'(acs >>> 16);
    nvf = 18'(s1_v) + acr;
    pvs = 34'(s1_pv) + 34'sd128;
    p_rnd = 25'(pvs >>> 8);
    priority if (nvf > 18'sd32767) begin
      nv_sat = 16'sh7fff;
      nv_flag = 1'b1;
    end else if (nvf < -18'sd32768) begin
      nv_sat = -16'sh8000;
      nv_flag = 1'b1;
    end else begin
      nv_sat = 16'(nvf);
      nv_flag = 1'b0;
    end
  end

  logic signed [15:0] s2_nv;
  logic               s2_fs;
  logic signed [41:0] s2_pdt;
  logic               s2_neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_nv <= nv_sat;
      s2_fs <= nv_flag;
      s2_pdt <= 42'(p_rnd) * 42'(dt_s);
      s2_neg <= s1_neg;
    end
  end

  logic signed [42:0] pdts;
  logic signed [25:0] q_rnd;
  logic signed [25:0] s3_qn;

  assign pdts = 43'(s2_pdt) + 43'sd32768;
  assign q_rnd = 26'(pdts >>> 16);

  // sign of the steering moves onto q, same product
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_qn <= s2_neg ? -q_rnd : q_rnd;
    end
  end

  logic [16:0]        sp_e;
  logic signed [25:0] qn_t;

  kbs_delay #(.W(17), .N(E_STAGE - 2)) u_dly_speed (
    .clk (clk), .en (adv), .d ({s2_nv, s2_fs}), .q (sp_e)
  );

  kbs_delay #(.W(26), .N(T_STAGE - 3)) u_dly_qn (
    .clk (clk), .en (adv), .d (s3_qn), .q (qn_t)
  );

  // ---------------------------------------------------------------
  // pose carried alongside the sines to stage 15
  // ---------------------------------------------------------------
  logic [95:0]        pose_15;
  logic [15:0]        hd_15;
  logic signed [15:0] v_15;
  logic signed [31:0] px_15;
  logic signed [31:0] py_15;

  kbs_delay #(.W(96), .N(QSIN_LAT)) u_dly_pose (
    .clk (clk), .en (adv), .d ({s0_hd, s0_v, s0_px, s0_py}), .q (pose_15)
  );

  assign hd_15 = pose_15[95:80];
  assign v_15 = $signed(pose_15[79:64]);
  assign px_15 = $signed(pose_15[63:32]);
  assign py_15 = $signed(pose_15[31:0]);

  // ---------------------------------------------------------------
  // position path, stages 16..19
  // ---------------------------------------------------------------
  logic signed [TW-1:0] sa_s;
  logic signed [TW-1:0] ca_s;
  logic signed [TW-1:0] c_sel;
  logic signed [TW-1:0] s_sel;

  assign sa_s = $signed({1'b0, to_trig(sin_a)});
  assign ca_s = $signed({1'b0, to_trig(cos_a)});

  // quadrant symmetry
  always_comb begin
    unique case (hd_15[15:14])
      QUAD_I: begin
        c_sel = ca_s;
        s_sel = sa_s;
      end
      QUAD_II: begin
        c_sel = -sa_s;
        s_sel = ca_s;
      end
      QUAD_III: begin
        c_sel = -ca_s;
        s_sel = -sa_s;
      end
      QUAD_IV: begin
        c_sel = sa_s;
        s_sel = -ca_s;
      end
      default: begin
        c_sel = ca_s;
        s_sel = sa_s;
      end
    endcase
  end

  logic signed [TW-1:0]    s16_c;
  logic signed [TW-1:0]    s16_s;
  logic signed [15:0]      s16_v;
  logic signed [31:0]      s16_px;
  logic signed [31:0]      s16_py;
  logic signed [TW+15:0]   s17_vc;
  logic signed [TW+15:0]   s17_vs;
  logic signed [31:0]      s17_px;
  logic signed [31:0]      s17_py;
  logic signed [VW-1:0]    s18_vcd;
  logic signed [VW-1:0]    s18_vsd;
  logic signed [31:0]      s18_px;
  logic signed [31:0]      s18_py;

  always_ff @(posedge clk) begin
    if (adv) begin
      s16_c <= c_sel;
      s16_s <= s_sel;
      s16_v <= v_15;
      s16_px <= px_15;
      s16_py <= py_15;
      s17_vc <= (TW + 16)'(s16_v) * (TW + 16)'(s16_c);
      s17_vs <= (TW + 16)'(s16_v) * (TW + 16)'(s16_s);
      s17_px <= s16_px;
      s17_py <= s16_py;
      s18_vcd <= VW'(s17_vc) * VW'(dt_s);
      s18_vsd <= VW'(s17_vs) * VW'(dt_s);
      s18_px <= s17_px;
      s18_py <= s17_py;
    end
  end

  logic signed [VW:0]  rxs;
  logic signed [VW:0]  rys;
  logic signed [33:0]  sx;
  logic signed [33:0]  sy;
  logic signed [31:0]  nx_sat;
  logic signed [31:0]  ny_sat;
  logic                fx;
  logic                fy;

  always_comb begin
    rxs = (VW + 1)'(s18_vcd) + POS_HALF;
    rys = (VW + 1)'(s18_vsd) + POS_HALF;
    sx = 34'(s18_px) + 34'(rxs >>> (8 + F));
    sy = 34'(s18_py) + 34'(rys >>> (8 + F));
    priority if (sx > 34'sd2147483647) begin
      nx_sat = 32'sh7fff_ffff;
      fx = 1'b1;
    end else if (sx < -34'sd2147483648) begin
      nx_sat = 32'sh8000_0000;
      fx = 1'b1;
    end else begin
      nx_sat = 32'(sx);
      fx = 1'b0;
    end
    priority if (sy > 34'sd2147483647) begin
      ny_sat = 32'sh7fff_ffff;
      fy = 1'b1;
    end else if (sy < -34'sd2147483648) begin
      ny_sat = 32'sh8000_0000;
      fy = 1'b1;
    end else begin
      ny_sat = 32'(sy);
      fy = 1'b0;
    end
  end

  logic signed [31:0] s19_nx;
  logic signed [31:0] s19_ny;
  logic               s19_fp;

  always_ff @(posedge clk) begin
    if (adv) begin
      s19_nx <= nx_sat;
      s19_ny <= ny_sat;
      s19_fp <= fx | fy;
    end
  end

  logic [64:0] pos_e;

  kbs_delay #(.W(65), .N(E_STAGE - POS_STAGE)) u_dly_pos (
    .clk (clk), .en (adv), .d ({s19_nx, s19_ny, s19_fp}), .q (pos_e)
  );

  // ---------------------------------------------------------------
  // heading path after the tangent, stages T+1..T+4
  // ---------------------------------------------------------------
  logic [15:0] hd_t3;

  kbs_delay #(.W(16), .N(QW + 3)) u_dly_hd (
    .clk (clk), .en (adv), .d (hd_15), .q (hd_t3)
  );

  logic signed [QTW-1:0] st_qt;
  logic signed [41:0]    st_w;
  logic [47:0]           st_wc;
  logic [15:0]           e_heading;
  logic signed [QTW-1:0] qt_rnd;
  logic [47:0]           wc_rnd;

  assign qt_rnd = st_qt + W_HALF;
  assign wc_rnd = st_wc + 48'h0000_8000_0000;

  // angle rate to binary units, only low 48 bits of the product matter
  always_ff @(posedge clk) begin
    if (adv) begin
      st_qt <= QTW'(qn_t) * QTW'($signed({1'b0, tan_mag}));
      st_w <= 42'(qt_rnd >>> F);
      st_wc <= 48'(st_w) * 48'(INV2PI_Q32);
      e_heading <= hd_t3 + wc_rnd[47:32];
    end
  end

  // ---------------------------------------------------------------
  // two-entry output queue
  // ---------------------------------------------------------------
  kbs_out_t res;
  kbs_out_t q_head;
  kbs_out_t q_tail;
  logic     push;
  logic     pop;

  assign res.next_x = $signed(pos_e[64:33]);
  assign res.next_y = $signed(pos_e[32:1]);
  assign res.next_heading = e_heading;
  assign res.next_speed = $signed(sp_e[16:1]);
  assign res.saturated = pos_e[0] | sp_e[0];

  assign push = vld[E_STAGE] && adv;
  assign pop = (q_count != 2'd0) && out_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else begin
      q_count <= q_count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_count == 2'd2 && pop) begin
      q_head <= q_tail;
    end else if (push && (q_count == 2'd0 || (q_count == 2'd1 && pop))) begin
      q_head <= res;
    end
    if (push && ((q_count == 2'd1 && !pop) || q_count == 2'd2)) begin
      q_tail <= res;
    end
  end

  assign out_stream.valid = (q_count != 2'd0);
  assign out_stream.data = q_head;

endmodule
